// ===== sv/motor_speed_pid_to_pwm_top_defines.svh =====
// Assertion macros shared by the checker of the speed controller.
`ifndef MOTOR_SPEED_PID_TO_PWM_TOP_DEFINES_SVH
`define MOTOR_SPEED_PID_TO_PWM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSPWM_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSPWM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mspwm_pkg.sv =====
// Types, constants and the control program of the speed controller.
`default_nettype none
package mspwm_pkg;

	localparam int unsigned GAIN_FRAC_BITS_DEF = 24;

	localparam int unsigned GAIN_W  = 25;
	localparam int unsigned HZ_W    = 16;
	localparam int unsigned TGT_W   = 11;
	localparam int unsigned ERR_W   = 18;
	localparam int unsigned SUM_W   = 48;
	localparam int unsigned SPLIT_W = 24;
	localparam int unsigned MB_W    = 25;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned IDX_LSB = 2;
	localparam int unsigned PC_W    = 4;

	// The upper half of ki*I is held within +-2^26 before it is shifted up.
	// Past that point the total is so far outside one that the clamp decides alone.
	// The held value needs a sign bit on top of 2^26 itself.
	localparam int unsigned HI_LIM_LOG2 = 26;
	localparam int unsigned HI_C_W      = HI_LIM_LOG2 + 2;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 25'd1678;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 25'd839;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 25'd168;
	localparam logic [HZ_W-1:0]   PWM_NEUTRAL_RST = 16'd1500;
	localparam logic [HZ_W-1:0]   PWM_SPAN_RST    = 16'd500;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_PWM_NEUTRAL = 3'd3,
		REG_PWM_SPAN    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_KP_E   = 3'd0,
		MUL_KD_DE  = 3'd1,
		MUL_KI_LO  = 3'd2,
		MUL_KI_HI  = 3'd3,
		MUL_U_SPAN = 3'd4
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD   = 2'd0,
		ACC_CLEAR  = 2'd1,
		ACC_ADD_P  = 2'd2,
		ACC_ADD_HI = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		JC_NONE       = 2'd0,
		JC_NOT_ACCEPT = 2'd1,
		JC_OUT_BUSY   = 2'd2
	} jump_cond_t;

	typedef struct packed {
		jump_cond_t      cond;
		logic [PC_W-1:0] target;
		logic            last;
		logic            front_en;
		logic            mul_en;
		mul_sel_t        mul_sel;
		acc_op_t         acc_op;
		logic            clamp_en;
		logic            load_out;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] PC_KP     = 4'd1;
	localparam logic [PC_W-1:0] PC_KD     = 4'd2;
	localparam logic [PC_W-1:0] PC_KI_LO  = 4'd3;
	localparam logic [PC_W-1:0] PC_KI_HI  = 4'd4;
	localparam logic [PC_W-1:0] PC_SUM_HI = 4'd5;
	localparam logic [PC_W-1:0] PC_CLAMP  = 4'd6;
	localparam logic [PC_W-1:0] PC_SCALE  = 4'd7;
	localparam logic [PC_W-1:0] PC_FINISH = 4'd8;

	// Control store: one word per step of the program.
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{cond: JC_NONE, target: PC_WAIT, last: 1'b0, front_en: 1'b0, mul_en: 1'b0,
			mul_sel: MUL_KP_E, acc_op: ACC_HOLD, clamp_en: 1'b0, load_out: 1'b0};
		case (pc)
			PC_WAIT: begin
				w.cond     = JC_NOT_ACCEPT;
				w.target   = PC_WAIT;
				w.front_en = 1'b1;
				w.acc_op   = ACC_CLEAR;
			end
			PC_KP: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_KP_E;
			end
			PC_KD: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_KD_DE;
				w.acc_op  = ACC_ADD_P;
			end
			PC_KI_LO: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_KI_LO;
				w.acc_op  = ACC_ADD_P;
			end
			PC_KI_HI: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_KI_HI;
				w.acc_op  = ACC_ADD_P;
			end
			PC_SUM_HI: begin
				w.acc_op = ACC_ADD_HI;
			end
			PC_CLAMP: begin
				w.clamp_en = 1'b1;
			end
			PC_SCALE: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_U_SPAN;
			end
			PC_FINISH: begin
				w.cond     = JC_OUT_BUSY;
				w.target   = PC_FINISH;
				w.last     = 1'b1;
				w.load_out = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mspwm_ifs.sv =====
// Handshake channels of the speed controller: request in, result out.
`default_nettype none
interface mspwm_req_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [mspwm_pkg::TGT_W-1:0]        target_hz;
	logic        [mspwm_pkg::HZ_W-1:0]         measured_hz;

	modport source (output valid, output target_hz, output measured_hz, input ready);
	modport sink (input valid, input target_hz, input measured_hz, output ready);
endinterface

interface mspwm_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [mspwm_pkg::HZ_W-1:0]       pwm_compare;
	logic                             drive_clamped;

	modport source (output valid, output pwm_compare, output drive_clamped, input ready);
	modport sink (input valid, input pwm_compare, input drive_clamped, output ready);
endinterface
`default_nettype wire

// ===== sv/motor_speed_pid_to_pwm_top.sv =====
// Speed PID controller that turns a target and a measured frequency into a PWM compare value.
`default_nettype none
// Each request on speed carries a target and a measured motor frequency in hertz; the block
// answers with one result on drive: the PWM compare value and a flag that is set when the
// controller output ran into a limit. A negative target counts as zero. The error feeds a
// 48-bit saturating integral and a difference against the previous error, and the three
// terms are weighted by the gains (GAIN_FRAC_BITS fraction bits, so one is
// 2^GAIN_FRAC_BITS), clamped to plus or minus one and mapped onto
// pwm_neutral .. pwm_neutral+pwm_span. A new request is taken only when the program is back
// at its first step: one 25-bit by 25-bit multiplier is shared by all products, and a
// nine-step program in a read-only control store walks the datapath through them, one
// product per step. The result register loads in the last step; while it holds a result not
// yet taken the next request is already accepted and worked on, and the program waits in
// its last step only if a second result is ready before the first one has left. Gains and
// the PWM window sit behind an APB port at byte addresses 0, 4, 8, 12 and 16 and read back;
// they are meant to be written only while no request is in flight.
module motor_speed_pid_to_pwm_top #(
	parameter int unsigned GAIN_FRAC_BITS = mspwm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	mspwm_req_if.sink                                 speed,
	mspwm_rsp_if.source                               drive,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [mspwm_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [mspwm_pkg::DATA_W-1:0]         pwdata,
	output logic      [mspwm_pkg::DATA_W-1:0]         prdata,
	output logic                                      pready
);

	// The multiplier's unsigned operand carries either a gain or the clamped drive u,
	// which needs one bit above the fraction to hold exactly one.
	localparam int unsigned U_W   = GAIN_FRAC_BITS + 1;
	localparam int unsigned MA_W  = (U_W > mspwm_pkg::GAIN_W) ? U_W : mspwm_pkg::GAIN_W;
	localparam int unsigned P_W   = MA_W + 1 + mspwm_pkg::MB_W;
	localparam int unsigned ACC_W = P_W + 2;
	localparam int unsigned ERR_W = mspwm_pkg::ERR_W;
	localparam int unsigned SUM_W = mspwm_pkg::SUM_W;
	localparam int unsigned HZ_W  = mspwm_pkg::HZ_W;
	localparam int unsigned GN_W  = mspwm_pkg::GAIN_W;
	localparam int unsigned SPL_W = mspwm_pkg::SPLIT_W;
	localparam int unsigned HC_W  = mspwm_pkg::HI_C_W;

	localparam logic signed [ACC_W-1:0] ONE     = $signed(ACC_W'(1) << GAIN_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] NEG_ONE = -ONE;
	localparam logic signed [P_W-1:0]   HI_LIM  = $signed(P_W'(1) << mspwm_pkg::HI_LIM_LOG2);
	localparam logic signed [P_W-1:0]   HI_LIM_N = -HI_LIM;

	// Configuration registers.
	logic [GN_W-1:0] prop_gain_q;
	logic [GN_W-1:0] integ_gain_q;
	logic [GN_W-1:0] deriv_gain_q;
	logic [HZ_W-1:0] pwm_neutral_q;
	logic [HZ_W-1:0] pwm_span_q;

	logic                          cfg_wr;
	mspwm_pkg::reg_idx_t           cfg_idx;

	// Sequencer.
	logic [mspwm_pkg::PC_W-1:0]    pc_q;
	logic [mspwm_pkg::PC_W-1:0]    pc_d;
	mspwm_pkg::ucode_t             cw;
	logic                          accept;
	logic                          out_busy;
	logic                          jump;

	// Controller state and working registers.
	logic signed [ERR_W-1:0]       last_err_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [ERR_W-1:0]       e_q;
	logic signed [ERR_W-1:0]       de_q;
	logic signed [P_W-1:0]         p_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic        [U_W-1:0]         u_q;
	logic                          neg_q;
	logic                          clamp_q;

	// Result register.
	logic                          out_valid_q;
	logic [HZ_W-1:0]               out_pwm_q;
	logic                          out_flag_q;

	// Front end.
	logic [mspwm_pkg::TGT_W-2:0]   tgt_pos;
	logic signed [ERR_W-1:0]       e_d;
	logic signed [ERR_W-1:0]       de_d;
	logic signed [SUM_W:0]         sum_wide;
	logic signed [SUM_W-1:0]       sum_d;

	// Datapath.
	logic [MA_W-1:0]                     mul_a;
	logic signed [mspwm_pkg::MB_W-1:0]   mul_b;
	logic signed [P_W-1:0]               prod;
	logic signed [HC_W-1:0]              hi_c;
	logic signed [ACC_W-1:0]             hi_term;
	logic signed [ACC_W-1:0]             acc_d;
	logic [HZ_W-1:0]                     quot;
	logic [HZ_W:0]                       mapped;
	logic [HZ_W:0]                       top;
	logic [HZ_W:0]                       pwm_lim;
	logic                                pwm_ovf;
	logic [HZ_W-1:0]                     pwm_fin;
	logic                                flag_fin;

	// ---------------------------------------------------------------------------------------
	// APB configuration port. Writes complete in the access phase; there are no wait states.
	// ---------------------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = mspwm_pkg::reg_idx_t'(paddr[mspwm_pkg::PADDR_W-1:mspwm_pkg::IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= mspwm_pkg::PROP_GAIN_RST;
			integ_gain_q  <= mspwm_pkg::INTEG_GAIN_RST;
			deriv_gain_q  <= mspwm_pkg::DERIV_GAIN_RST;
			pwm_neutral_q <= mspwm_pkg::PWM_NEUTRAL_RST;
			pwm_span_q    <= mspwm_pkg::PWM_SPAN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mspwm_pkg::REG_PROP_GAIN:   prop_gain_q   <= pwdata[GN_W-1:0];
				mspwm_pkg::REG_INTEG_GAIN:  integ_gain_q  <= pwdata[GN_W-1:0];
				mspwm_pkg::REG_DERIV_GAIN:  deriv_gain_q  <= pwdata[GN_W-1:0];
				mspwm_pkg::REG_PWM_NEUTRAL: pwm_neutral_q <= pwdata[HZ_W-1:0];
				mspwm_pkg::REG_PWM_SPAN:    pwm_span_q    <= pwdata[HZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mspwm_pkg::REG_PROP_GAIN:   prdata = mspwm_pkg::DATA_W'(prop_gain_q);
			mspwm_pkg::REG_INTEG_GAIN:  prdata = mspwm_pkg::DATA_W'(integ_gain_q);
			mspwm_pkg::REG_DERIV_GAIN:  prdata = mspwm_pkg::DATA_W'(deriv_gain_q);
			mspwm_pkg::REG_PWM_NEUTRAL: prdata = mspwm_pkg::DATA_W'(pwm_neutral_q);
			mspwm_pkg::REG_PWM_SPAN:    prdata = mspwm_pkg::DATA_W'(pwm_span_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Sequencer. The control word of the current step comes from the read-only program in
	// the package. A step either falls through, returns to the start after the last step,
	// or jumps to its target when its condition holds; both conditional steps jump to
	// themselves, which is how the program waits for a request and for a free result slot.
	// ---------------------------------------------------------------------------------------
	assign cw          = mspwm_pkg::ucode(pc_q);
	assign speed.ready = cw.front_en;
	assign accept      = speed.valid & speed.ready;
	assign out_busy    = out_valid_q & ~drive.ready;

	always_comb begin
		case (cw.cond)
			mspwm_pkg::JC_NOT_ACCEPT: jump = ~accept;
			mspwm_pkg::JC_OUT_BUSY:   jump = out_busy;
			default:                  jump = 1'b0;
		endcase
		if (jump) begin
			pc_d = cw.target;
		end else if (cw.last) begin
			pc_d = mspwm_pkg::PC_WAIT;
		end else begin
			pc_d = pc_q + mspwm_pkg::PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mspwm_pkg::PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Front end, taken with the request: error, difference and the saturating integral.
	// The error spans -65535 .. 1023 and the difference of two errors still fits 18 bits.
	// ---------------------------------------------------------------------------------------
	assign tgt_pos  = speed.target_hz[mspwm_pkg::TGT_W-1] ? '0 :
		speed.target_hz[mspwm_pkg::TGT_W-2:0];
	assign e_d      = $signed(ERR_W'(tgt_pos)) - $signed(ERR_W'(speed.measured_hz));
	assign de_d     = e_d - last_err_q;
	assign sum_wide = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W+1)'(e_d);
	assign sum_d    = (sum_wide[SUM_W] != sum_wide[SUM_W-1]) ?
		(sum_wide[SUM_W] ? mspwm_pkg::SUM_MIN : mspwm_pkg::SUM_MAX) :
		sum_wide[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			sum_q      <= '0;
		end else if (accept) begin
			last_err_q <= e_d;
			sum_q      <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q  <= e_d;
			de_q <= de_d;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Shared multiplier. The integral is split into a signed upper and an unsigned lower
	// 24-bit half so that every product stays within one 25 by 25 bit multiply; the two
	// halves are summed back in the accumulator.
	// ---------------------------------------------------------------------------------------
	always_comb begin
		case (cw.mul_sel)
			mspwm_pkg::MUL_KP_E: begin
				mul_a = MA_W'(prop_gain_q);
				mul_b = mspwm_pkg::MB_W'(e_q);
			end
			mspwm_pkg::MUL_KD_DE: begin
				mul_a = MA_W'(deriv_gain_q);
				mul_b = mspwm_pkg::MB_W'(de_q);
			end
			mspwm_pkg::MUL_KI_LO: begin
				mul_a = MA_W'(integ_gain_q);
				mul_b = $signed({1'b0, sum_q[SPL_W-1:0]});
			end
			mspwm_pkg::MUL_KI_HI: begin
				mul_a = MA_W'(integ_gain_q);
				mul_b = $signed({sum_q[SUM_W-1], sum_q[SUM_W-1:SPL_W]});
			end
			mspwm_pkg::MUL_U_SPAN: begin
				mul_a = MA_W'(u_q);
				mul_b = $signed(mspwm_pkg::MB_W'(pwm_span_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = $signed({1'b0, mul_a}) * mul_b;

	always_ff @(posedge clk) begin
		if (cw.mul_en) begin
			p_q <= prod;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Accumulator. The upper integral product is held within +-2^26 before its shift; a
	// larger one would put the sum far outside one with the same sign, so the clamp below
	// gives the same answer.
	// ---------------------------------------------------------------------------------------
	always_comb begin
		if (p_q > HI_LIM) begin
			hi_c = HI_LIM[HC_W-1:0];
		end else if (p_q < HI_LIM_N) begin
			hi_c = HI_LIM_N[HC_W-1:0];
		end else begin
			hi_c = p_q[HC_W-1:0];
		end
		hi_term = $signed({{(ACC_W-HC_W-SPL_W){hi_c[HC_W-1]}}, hi_c, SPL_W'(0)});
		case (cw.acc_op)
			mspwm_pkg::ACC_CLEAR:  acc_d = '0;
			mspwm_pkg::ACC_ADD_P:  acc_d = acc_q + ACC_W'(p_q);
			mspwm_pkg::ACC_ADD_HI: acc_d = acc_q + hi_term;
			default:               acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	// Clamp of u to [-one, +one]. A negative u drives the neutral value, so only its sign
	// is kept and the scaling step multiplies by zero.
	always_ff @(posedge clk) begin
		if (cw.clamp_en) begin
			neg_q   <= acc_q[ACC_W-1];
			clamp_q <= (acc_q > ONE) || (acc_q < NEG_ONE);
			if (acc_q[ACC_W-1]) begin
				u_q <= '0;
			end else if (acc_q > ONE) begin
				u_q <= ONE[U_W-1:0];
			end else begin
				u_q <= acc_q[U_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Mapping onto the PWM window and the result register.
	// ---------------------------------------------------------------------------------------
	assign quot     = p_q[GAIN_FRAC_BITS +: HZ_W];
	assign mapped   = {1'b0, pwm_neutral_q} + {1'b0, quot};
	assign top      = {1'b0, pwm_neutral_q} + {1'b0, pwm_span_q};
	assign pwm_lim  = (mapped > top) ? top : mapped;
	assign pwm_ovf  = pwm_lim[HZ_W];
	assign pwm_fin  = pwm_ovf ? {HZ_W{1'b1}} : pwm_lim[HZ_W-1:0];
	assign flag_fin = clamp_q | (neg_q & (pwm_span_q != '0)) | pwm_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.load_out && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.load_out && !out_busy) begin
			out_pwm_q  <= pwm_fin;
			out_flag_q <= flag_fin;
		end
	end

	assign drive.valid         = out_valid_q;
	assign drive.pwm_compare   = out_pwm_q;
	assign drive.drive_clamped = out_flag_q;

endmodule
`default_nettype wire

// ===== sv/mspwm_chk.sv =====
// Port checker of the speed controller and its bind to the top level.
`default_nettype none
`include "motor_speed_pid_to_pwm_top_defines.svh"
module mspwm_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [mspwm_pkg::HZ_W-1:0]     out_pwm,
	input wire logic                           out_flag
);

	// Only one request is worked on at a time.
	`MSPWM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while another is in flight")

	// A result never shows up in the cycle right after its request.
	`MSPWM_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

	// A new result is loaded only from the last program step, where requests are refused.
	`MSPWM_ASSERT_NOW(a_result_from_last_step, clk, arst_n, $rose(out_valid), $past(!in_ready), "result loaded outside the last step")

	// A stalled result keeps its value.
	`MSPWM_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_pwm) && $stable(out_flag), "stalled result changed")

endmodule

bind motor_speed_pid_to_pwm_top mspwm_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (speed.valid),
	.in_ready  (speed.ready),
	.out_valid (drive.valid),
	.out_ready (drive.ready),
	.out_pwm   (drive.pwm_compare),
	.out_flag  (drive.drive_clamped)
);
`default_nettype wire
